FILE: src/utcep_pkg.sv
// Package for the timestamp-to-epoch-seconds block: widths, status codes,
// character and position constants, and the cumulative month-day table.
// No dependencies.
package utcep_pkg;

  localparam int CharW  = 8;
  localparam int PosW   = 5;
  localparam int YearW  = 14;
  localparam int FieldW = 7;
  localparam int DaysW  = 22;
  localparam int SecsW  = 38;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [PosW-1:0]   pos_t;
  typedef logic [YearW-1:0]  year_t;
  typedef logic [FieldW-1:0] field_t;
  typedef logic [DaysW-1:0]  days_t;
  typedef logic [SecsW-1:0]  secs_t;

  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_COLON = 8'h3A;
  localparam char_t CH_T     = 8'h54;
  localparam char_t CH_Z     = 8'h5A;

  localparam pos_t POS_YEAR_DASH  = 5'd4;
  localparam pos_t POS_YEAR_CALC  = 5'd5;
  localparam pos_t POS_MONTH_DASH = 5'd7;
  localparam pos_t POS_T          = 5'd10;
  localparam pos_t POS_DAY_MUL    = 5'd11;
  localparam pos_t POS_HOUR_COLON = 5'd13;
  localparam pos_t POS_MIN_COLON  = 5'd16;
  localparam pos_t POS_Z          = 5'd19;
  localparam pos_t POS_LEN        = 5'd20;
  localparam pos_t POS_MAX        = 5'd31;

  localparam int EPOCH_YEAR     = 1970;
  localparam int LEAPS_TO_EPOCH = 477;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int SECS_PER_DAY   = 86400;
  localparam int SECS_PER_HOUR  = 3600;
  localparam int SECS_PER_MIN   = 60;
  localparam int DIV100_MUL     = 5243;
  localparam int DIV100_SHIFT   = 19;

  function automatic logic [8:0] days_before_month(input logic [3:0] month_index);
    logic [8:0] days;
    case (month_index)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

FILE: src/utcep_ifs.sv
// Valid/ready channel interfaces for the character input and the result output.
// Depends on utcep_pkg.
interface utcep_char_if;
  logic                  valid;
  logic                  ready;
  logic [utcep_pkg::CharW-1:0] char_code;
  logic                  last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface utcep_result_if;
  logic                        valid;
  logic                        ready;
  utcep_pkg::status_t          status;
  logic [utcep_pkg::SecsW-1:0] epoch_seconds;

  modport source (output valid, output status, output epoch_seconds, input ready);
  modport sink   (input valid, input status, input epoch_seconds, output ready);
endinterface

FILE: src/utc_timestamp_to_epoch_seconds.sv
// Timestamp parser: checks YYYY-MM-DDTHH:MM:SSZ and converts it to epoch seconds.
// Depends on utcep_pkg and the channel interfaces in utcep_ifs.sv.
//
// Usage: the chars channel carries one character word per cycle, with
// last_char set on the final character of a string. Each word is checked
// and folded into the field accumulators as it is taken. Only the last
// character of a string gives a word on the result channel: a status
// (ok, malformed, out of range) and, when ok, the seconds since the epoch.
// The result is registered and is valid in the cycle after the last
// character is taken; one character is taken every cycle while chars.ready
// is high, so the throughput is one character per cycle. The day count and
// seconds total are built up in steps at fixed character positions while the
// string streams in, so the final cycle holds only the range check and one add.
// The result sits in an output register; while a result word waits on a
// stalled receiver, chars.ready is low and no character is taken until the
// waiting word has gone.
// Reset clears the position count, the error flag, the field accumulators and
// the result valid flag; the block is ready in the first cycle after reset.
module utc_timestamp_to_epoch_seconds (
  input logic            clk,
  input logic            rst,
  utcep_char_if.sink     chars,
  utcep_result_if.source result
);
  import utcep_pkg::*;

  pos_t   pos;
  logic   format_bad;
  year_t  year_acc;
  field_t month_acc;
  field_t day_acc;
  field_t hour_acc;
  field_t minute_acc;
  field_t second_acc;

  logic [11:0] quot4;
  logic [7:0]  quot100;
  logic        leap;
  days_t       days;
  secs_t       secs;

  logic        accept_in;
  logic        finish;
  logic        is_digit;
  logic        char_bad;
  logic [3:0]  digit;
  year_t       year_m1;
  logic [26:0] div100_prod;
  year_t       rem100;
  year_t       rem400;
  logic [5:0]  quot400;
  days_t       year_days;
  year_t       year_off;
  logic        range_bad;
  status_t     status_next;
  secs_t       epoch_next;

  function automatic field_t acc_field(input field_t acc, input logic [3:0] d);
    return FieldW'(acc * 7'd10 + FieldW'(d));
  endfunction

  // A string may finish only when the result register is free or emptying.
  assign chars.ready = !result.valid || result.ready;
  assign accept_in   = chars.valid && chars.ready;
  assign finish      = accept_in && chars.last_char;

  assign is_digit = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
  assign digit    = 4'(chars.char_code - CH_ZERO);

  always_comb begin
    char_bad = 1'b0;
    if (pos >= POS_LEN) begin
      char_bad = 1'b1;
    end else if (pos == POS_YEAR_DASH || pos == POS_MONTH_DASH) begin
      char_bad = (chars.char_code != CH_DASH);
    end else if (pos == POS_T) begin
      char_bad = (chars.char_code != CH_T);
    end else if (pos == POS_HOUR_COLON || pos == POS_MIN_COLON) begin
      char_bad = (chars.char_code != CH_COLON);
    end else if (pos == POS_Z) begin
      char_bad = (chars.char_code != CH_Z);
    end else begin
      char_bad = !is_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      format_bad <= 1'b0;
      year_acc   <= '0;
      month_acc  <= '0;
      day_acc    <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      second_acc <= '0;
    end else if (finish) begin
      pos        <= '0;
      format_bad <= 1'b0;
      year_acc   <= '0;
      month_acc  <= '0;
      day_acc    <= '0;
      hour_acc   <= '0;
      minute_acc <= '0;
      second_acc <= '0;
    end else if (accept_in) begin
      if (pos != POS_MAX) begin
        pos <= pos + 5'd1;
      end
      if (char_bad) begin
        format_bad <= 1'b1;
      end else if (is_digit) begin
        if (pos < POS_YEAR_DASH) begin
          year_acc <= YearW'(year_acc * 14'd10 + YearW'(digit));
        end else if (pos < POS_MONTH_DASH) begin
          month_acc <= acc_field(month_acc, digit);
        end else if (pos < POS_T) begin
          day_acc <= acc_field(day_acc, digit);
        end else if (pos < POS_HOUR_COLON) begin
          hour_acc <= acc_field(hour_acc, digit);
        end else if (pos < POS_MIN_COLON) begin
          minute_acc <= acc_field(minute_acc, digit);
        end else if (pos < POS_Z) begin
          second_acc <= acc_field(second_acc, digit);
        end
      end
    end
  end

  // Leap years in 1..year-1 come from the quotients by 4, 100 and 400.
  always_comb begin
    year_m1     = year_acc - 14'd1;
    div100_prod = 27'(year_m1 * 13'(DIV100_MUL));
    quot400     = quot100[7:2];
    rem100      = YearW'(year_m1 - YearW'(quot100 * 7'd100));
    rem400      = YearW'(year_m1 - YearW'(quot400 * 9'd400));
    year_off    = YearW'(year_acc - YearW'(EPOCH_YEAR));
    year_days   = DaysW'(year_off * 9'(DAYS_PER_YEAR)) + DaysW'(quot4)
                - DaysW'(quot100) + DaysW'(quot400) - DaysW'(LEAPS_TO_EPOCH);
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      case (pos)
        POS_YEAR_DASH: begin
          quot4   <= year_m1[13:2];
          quot100 <= div100_prod[26:DIV100_SHIFT];
        end
        POS_YEAR_CALC: begin
          leap <= (year_acc[1:0] == 2'd0) && ((rem100 != 14'd99) || (rem400 == 14'd399));
          days <= year_days;
        end
        POS_MONTH_DASH: begin
          days <= days + DaysW'(days_before_month(4'(month_acc - 7'd1)))
                + DaysW'((month_acc > 7'd2) && leap);
        end
        POS_T: begin
          days <= days + DaysW'(day_acc) - DaysW'(1);
        end
        POS_DAY_MUL: begin
          secs <= SecsW'(days) * SecsW'(SECS_PER_DAY);
        end
        POS_HOUR_COLON: begin
          secs <= secs + SecsW'(hour_acc * 12'(SECS_PER_HOUR));
        end
        POS_MIN_COLON: begin
          secs <= secs + SecsW'(minute_acc * 6'(SECS_PER_MIN));
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    range_bad = (year_acc < YearW'(EPOCH_YEAR)) || (month_acc < 7'd1) || (month_acc > 7'd12)
             || (day_acc < 7'd1) || (day_acc > 7'd31) || (hour_acc > 7'd23)
             || (minute_acc > 7'd59) || (second_acc > 7'd60);
    epoch_next = '0;
    if (format_bad || char_bad || pos != POS_Z) begin
      status_next = ST_MALFORMED;
    end else if (range_bad) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
      epoch_next  = secs + SecsW'(second_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.status        <= status_next;
      result.epoch_seconds <= epoch_next;
    end
  end

endmodule

FILE: src/utcep_checker.sv
// Port-level checks for utc_timestamp_to_epoch_seconds, bound to the top level.
// Depends on utcep_pkg.
module utcep_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [utcep_pkg::SecsW-1:0] epoch_seconds
);
  import utcep_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid straight after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result word dropped");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result word without a last character");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MALFORMED || status == ST_RANGE))
    else $error("undefined status code");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> epoch_seconds == '0)
    else $error("nonzero seconds with an error status");

endmodule

bind utc_timestamp_to_epoch_seconds utcep_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (chars.valid),
  .in_ready      (chars.ready),
  .in_last       (chars.last_char),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .status        (result.status),
  .epoch_seconds (result.epoch_seconds)
);
